// ===== design/clock_counter_with_segment_display_defines.svh =====
// Assertion macros for the clock counter with segment display.
`ifndef CLOCK_COUNTER_WITH_SEGMENT_DISPLAY_DEFINES_SVH
`define CLOCK_COUNTER_WITH_SEGMENT_DISPLAY_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define CCSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define CCSD_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define CCSD_ASSERT(lbl, prop, msg)
`define CCSD_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// ===== design/ccsd_pkg.sv =====
// Types, constants and digit helpers shared by the clock counter modules.
`timescale 1ns / 1ps
package ccsd_pkg;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_LOAD = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    CFG_TICKS_PER_SECOND   = 2'd0,
    CFG_BLINK_POINT_FIRST  = 2'd1,
    CFG_BLINK_POINT_SECOND = 2'd2
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;

  localparam logic [7:0] TicksPerSecondRst   = 8'd56;
  localparam logic [7:0] BlinkPointFirstRst  = 8'd10;
  localparam logic [7:0] BlinkPointSecondRst = 8'd37;

  localparam logic [7:0] PrescaleRst  = 8'd0;
  localparam logic [5:0] SecondsRst   = 6'd30;
  localparam logic [5:0] MinutesRst   = 6'd31;
  localparam logic [4:0] HoursRst     = 5'd22;
  localparam logic       IndicatorRst = 1'b1;

  localparam logic [5:0] SecondsMax = 6'd59;
  localparam logic [5:0] MinutesMax = 6'd59;
  localparam logic [4:0] HoursMax   = 5'd23;

  localparam logic [7:0] SegBlank    = 8'hFF;
  localparam logic [7:0] RingOddBase = 8'hFE;

  typedef struct packed {
    op_e        operation;
    logic [4:0] load_hours;
    logic [5:0] load_minutes;
    logic [5:0] load_seconds;
  } in_t;

  typedef struct packed {
    logic [7:0] hour_tens_segments;
    logic [7:0] hour_ones_segments;
    logic [7:0] minute_tens_segments;
    logic [7:0] minute_ones_segments;
    logic [2:0] ring_group;
    logic [7:0] ring_pattern;
    logic       indicator_led;
  } out_t;

  typedef struct packed {
    logic [7:0] ticks_per_second;
    logic [7:0] blink_point_first;
    logic [7:0] blink_point_second;
  } cfg_t;

  typedef struct packed {
    logic [7:0] prescale;
    logic [5:0] seconds;
    logic [5:0] minutes;
    logic [4:0] hours;
    logic       indicator;
  } time_t;

  typedef struct packed {
    logic [2:0] tens;
    logic [3:0] ones;
  } digits_t;

  // active-low pattern, blank above nine
  function automatic logic [7:0] seg_encode(input logic [3:0] d);
    logic [7:0] p;
    unique case (d)
      4'd0:    p = 8'h40;
      4'd1:    p = 8'h79;
      4'd2:    p = 8'h24;
      4'd3:    p = 8'h30;
      4'd4:    p = 8'h19;
      4'd5:    p = 8'h12;
      4'd6:    p = 8'h02;
      4'd7:    p = 8'h78;
      4'd8:    p = 8'h00;
      4'd9:    p = 8'h10;
      default: p = SegBlank;
    endcase
    return p;
  endfunction

  function automatic digits_t split_dec(input logic [5:0] v);
    digits_t r;
    priority if (v >= 6'd60) begin
      r.tens = 3'd6; r.ones = 4'(v - 6'd60);
    end else if (v >= 6'd50) begin
      r.tens = 3'd5; r.ones = 4'(v - 6'd50);
    end else if (v >= 6'd40) begin
      r.tens = 3'd4; r.ones = 4'(v - 6'd40);
    end else if (v >= 6'd30) begin
      r.tens = 3'd3; r.ones = 4'(v - 6'd30);
    end else if (v >= 6'd20) begin
      r.tens = 3'd2; r.ones = 4'(v - 6'd20);
    end else if (v >= 6'd10) begin
      r.tens = 3'd1; r.ones = 4'(v - 6'd10);
    end else begin
      r.tens = 3'd0; r.ones = v[3:0];
    end
    return r;
  endfunction

endpackage

// ===== design/ccsd_cfg.sv =====
// Configuration registers: prescaler period and the two blink points.
`timescale 1ns / 1ps
module ccsd_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ccsd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ccsd_pkg::CfgDataW-1:0] cfg_data_i,
  output ccsd_pkg::cfg_t                cfg_o
);

  ccsd_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (ccsd_pkg::cfg_idx_e'(cfg_idx_i))
        ccsd_pkg::CFG_TICKS_PER_SECOND:   cfg_d.ticks_per_second   = cfg_data_i;
        ccsd_pkg::CFG_BLINK_POINT_FIRST:  cfg_d.blink_point_first  = cfg_data_i;
        ccsd_pkg::CFG_BLINK_POINT_SECOND: cfg_d.blink_point_second = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ticks_per_second   <= ccsd_pkg::TicksPerSecondRst;
      cfg_q.blink_point_first  <= ccsd_pkg::BlinkPointFirstRst;
      cfg_q.blink_point_second <= ccsd_pkg::BlinkPointSecondRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/ccsd_time.sv =====
// Time keeping: prescaler, seconds/minutes/hours carry chain, indicator toggle and time load.
`timescale 1ns / 1ps
module ccsd_time (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            acc_i,
  input  ccsd_pkg::in_t   word_i,
  input  ccsd_pkg::cfg_t  cfg_i,
  output ccsd_pkg::time_t time_d_o,
  output ccsd_pkg::time_t time_q_o
);

  ccsd_pkg::time_t time_q, time_d;
  logic [8:0] presc_inc;
  logic [5:0] sec_inc;
  logic [5:0] min_inc;
  logic [4:0] hr_inc;

  assign presc_inc = {1'b0, time_q.prescale} + 9'd1;
  assign sec_inc   = time_q.seconds + 6'd1;
  assign min_inc   = time_q.minutes + 6'd1;
  assign hr_inc    = time_q.hours + 5'd1;

  always_comb begin
    time_d = time_q;
    if (acc_i) begin
      unique case (word_i.operation)
        ccsd_pkg::OP_TICK: begin
          if (time_q.prescale == cfg_i.blink_point_first ||
              time_q.prescale == cfg_i.blink_point_second) begin
            time_d.indicator = ~time_q.indicator;
          end
          if (presc_inc >= {1'b0, cfg_i.ticks_per_second}) begin
            time_d.prescale = '0;
            time_d.seconds  = sec_inc;
            if (sec_inc > ccsd_pkg::SecondsMax) begin
              time_d.seconds = '0;
              time_d.minutes = min_inc;
              if (min_inc > ccsd_pkg::MinutesMax) begin
                time_d.minutes = '0;
                time_d.hours   = (hr_inc > ccsd_pkg::HoursMax) ? 5'd0 : hr_inc;
              end
            end
          end else begin
            time_d.prescale = presc_inc[7:0];
          end
        end
        ccsd_pkg::OP_LOAD: begin
          time_d.hours    = word_i.load_hours;
          time_d.minutes  = word_i.load_minutes;
          time_d.seconds  = word_i.load_seconds;
          time_d.prescale = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q.prescale  <= ccsd_pkg::PrescaleRst;
      time_q.seconds   <= ccsd_pkg::SecondsRst;
      time_q.minutes   <= ccsd_pkg::MinutesRst;
      time_q.hours     <= ccsd_pkg::HoursRst;
      time_q.indicator <= ccsd_pkg::IndicatorRst;
    end else begin
      time_q <= time_d;
    end
  end

  assign time_d_o = time_d;
  assign time_q_o = time_q;

endmodule

// ===== design/ccsd_disp.sv =====
// Display encoding of the updated time into the registered result word.
`timescale 1ns / 1ps
module ccsd_disp (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            acc_i,
  input  ccsd_pkg::time_t time_i,
  input  logic            out_ready_i,
  output logic            out_valid_o,
  output ccsd_pkg::out_t  out_word_o
);

  ccsd_pkg::digits_t hr_dig, min_dig;
  ccsd_pkg::out_t    word_d, word_q;
  logic              valid_q, valid_d;
  logic [2:0]        ring_k;

  assign hr_dig  = ccsd_pkg::split_dec({1'b0, time_i.hours});
  assign min_dig = ccsd_pkg::split_dec(time_i.minutes);
  assign ring_k  = time_i.seconds[2:0];

  always_comb begin
    word_d.hour_tens_segments   = (hr_dig.tens == 3'd0) ? ccsd_pkg::SegBlank
                                : ccsd_pkg::seg_encode({1'b0, hr_dig.tens});
    word_d.hour_ones_segments   = ccsd_pkg::seg_encode(hr_dig.ones);
    word_d.minute_tens_segments = ccsd_pkg::seg_encode({1'b0, min_dig.tens});
    word_d.minute_ones_segments = ccsd_pkg::seg_encode(min_dig.ones);
    word_d.ring_group           = time_i.seconds[5:3];
    // odd minute: bar fills; even minute: bar empties
    word_d.ring_pattern         = time_i.minutes[0] ? (ccsd_pkg::RingOddBase << ring_k)
                                                    : ~(ccsd_pkg::RingOddBase << ring_k);
    word_d.indicator_led        = time_i.indicator;
  end

  assign valid_d = acc_i | (valid_q & ~out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      word_q <= word_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_word_o  = word_q;

endmodule

// ===== design/clock_counter_with_segment_display.sv =====
// Top level: clock counter with seven-segment and seconds-ring display words.
//
//   channel  dir  handshake                 payload
//   in       in   in_valid_i / in_ready_o   in_word_i  (ccsd_pkg::in_t)
//   out      out  out_valid_o / out_ready_i out_word_o (ccsd_pkg::out_t)
//   cfg      in   cfg_we_i                  cfg_idx_i, cfg_data_i
//
// One word per cycle while the result is not stalled; its result shows in the cycle after acceptance.
// The result is held in the single result register after the time update.
// Reset loads 22:31:30, prescaler zero, indicator on, config 56/10/37.
// A stalled result holds in_ready_o low until the result is taken.
`timescale 1ns / 1ps
`include "clock_counter_with_segment_display_defines.svh"
module clock_counter_with_segment_display (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  ccsd_pkg::in_t                 in_word_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output ccsd_pkg::out_t                out_word_o,
  input  logic                          cfg_we_i,
  input  logic [ccsd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ccsd_pkg::CfgDataW-1:0] cfg_data_i
);

  ccsd_pkg::cfg_t  cfg;
  ccsd_pkg::time_t time_d, time_q;
  logic            in_acc;

  assign in_ready_o = ~out_valid_o | out_ready_i;
  assign in_acc     = in_valid_i & in_ready_o;

  ccsd_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  ccsd_time u_time (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .acc_i    (in_acc),
    .word_i   (in_word_i),
    .cfg_i    (cfg),
    .time_d_o (time_d),
    .time_q_o (time_q)
  );

  ccsd_disp u_disp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (in_acc),
    .time_i      (time_d),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o)
  );

  `CCSD_ASSERT(a_acc_gives_result, in_acc |=> out_valid_o, "accepted word produced no result")
  `CCSD_ASSERT(a_tick_presc_bound, (in_acc && in_word_i.operation == ccsd_pkg::OP_TICK) |=> (time_q.prescale == 8'd0 || time_q.prescale < $past(cfg.ticks_per_second)), "prescaler left at or above period")
  `CCSD_ASSERT(a_load_clears, (in_acc && in_word_i.operation == ccsd_pkg::OP_LOAD) |=> (time_q.prescale == 8'd0 && $stable(time_q.indicator)), "load did not clear prescaler or moved indicator")
  `CCSD_ASSERT_NEVER(a_idle_state_moves, !in_acc && (time_d != time_q), "time changed without an accepted word")

endmodule

// ===== tb/tb_clock_counter_with_segment_display.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the clock counter with its digit and seconds-ring display words.
module tb_clock_counter_with_segment_display;
  import ccsd_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  in_t in_word_i;
  logic out_valid_o;
  logic out_ready_i;
  out_t out_word_o;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  clock_counter_with_segment_display dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_word_i(in_word_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_word_o(out_word_o),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // clock state and register copies
  logic [7:0] tps, blink_a, blink_b;
  logic [7:0] pre;
  logic [5:0] sec, mins;
  logic [4:0] hrs;
  logic led;

  out_t pending_displays[$];
  int n_mismatch = 0;
  bit no_idle = 1'b0;

  function automatic logic [7:0] seven_seg(input int unsigned d);
    case (d)
      0: return 8'h40;
      1: return 8'h79;
      2: return 8'h24;
      3: return 8'h30;
      4: return 8'h19;
      5: return 8'h12;
      6: return 8'h02;
      7: return 8'h78;
      8: return 8'h00;
      9: return 8'h10;
      default: return SegBlank;
    endcase
  endfunction

  function automatic out_t advance_clock(input in_t w);
    int unsigned nxt;
    out_t r;
    if (w.operation == OP_TICK) begin
      if (pre == blink_a || pre == blink_b) led = ~led;
      nxt = int'(pre) + 1;
      if (nxt >= int'(tps)) begin
        pre = '0;
        sec = sec + 6'd1;
        if (sec > 6'd59) begin
          sec = '0;
          mins = mins + 6'd1;
          if (mins > 6'd59) begin
            mins = '0;
            hrs = hrs + 5'd1;
            if (hrs > 5'd23) hrs = '0;
          end
        end
      end else begin
        pre = 8'(nxt);
      end
    end else begin
      hrs = w.load_hours;
      mins = w.load_minutes;
      sec = w.load_seconds;
      pre = '0;
    end
    r.hour_tens_segments = (hrs / 10 == 0) ? SegBlank : seven_seg(hrs / 10);
    r.hour_ones_segments = seven_seg(hrs % 10);
    r.minute_tens_segments = seven_seg(mins / 10);
    r.minute_ones_segments = seven_seg(mins % 10);
    r.ring_group = sec[5:3];
    r.ring_pattern = mins[0] ? 8'(9'h0FE << sec[2:0]) : 8'((9'd2 << sec[2:0]) - 9'd1);
    r.indicator_led = led;
    return r;
  endfunction

  function automatic in_t tick_word();
    in_t w;
    w.operation = OP_TICK;
    w.load_hours = 5'($urandom);
    w.load_minutes = 6'($urandom);
    w.load_seconds = 6'($urandom);
    return w;
  endfunction

  function automatic in_t load_word(input logic [4:0] h, input logic [5:0] m,
                                    input logic [5:0] s);
    in_t w;
    w.operation = OP_LOAD;
    w.load_hours = h;
    w.load_minutes = m;
    w.load_seconds = s;
    return w;
  endfunction

  function automatic in_t random_word();
    in_t w;
    int unsigned pick;
    w = tick_word();
    pick = $urandom_range(0, 99);
    if (pick >= 82) begin
      w.operation = OP_LOAD;
      if (pick < 90) begin
        w.load_hours = 5'($urandom_range(0, 23));
        w.load_minutes = 6'($urandom_range(0, 59));
        w.load_seconds = 6'($urandom_range(0, 59));
      end else if (pick < 96) begin
        // close to a full carry chain
        w.load_hours = 5'($urandom_range(22, 23));
        w.load_minutes = 6'($urandom_range(58, 59));
        w.load_seconds = 6'($urandom_range(55, 59));
      end
    end
    return w;
  endfunction

  task automatic send_word(input in_t w);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i <= w;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    pending_displays.push_back(advance_clock(w));
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_displays.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic set_reg(input cfg_idx_e idx, input logic [7:0] v);
    drain_results();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_TICKS_PER_SECOND: tps = v;
      CFG_BLINK_POINT_FIRST: blink_a = v;
      CFG_BLINK_POINT_SECOND: blink_b = v;
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
      n_mismatch++;
    end
  endtask

  initial begin : result_checker
    out_t want;
    int stall;
    out_ready_i = 1'b0;
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      if (pending_displays.size() == 0) begin
        $error("result word with nothing pending");
        n_mismatch++;
      end else begin
        want = pending_displays.pop_front();
        check_field("hour_tens_segments", want.hour_tens_segments,
                    out_word_o.hour_tens_segments);
        check_field("hour_ones_segments", want.hour_ones_segments,
                    out_word_o.hour_ones_segments);
        check_field("minute_tens_segments", want.minute_tens_segments,
                    out_word_o.minute_tens_segments);
        check_field("minute_ones_segments", want.minute_ones_segments,
                    out_word_o.minute_ones_segments);
        check_field("ring_group", 8'(want.ring_group), 8'(out_word_o.ring_group));
        check_field("ring_pattern", want.ring_pattern, out_word_o.ring_pattern);
        check_field("indicator_led", 8'(want.indicator_led), 8'(out_word_o.indicator_led));
      end
    end
  end

  task automatic test_reset_time();
    send_word(tick_word());
  endtask

  task automatic test_load_extremes();
    send_word(load_word(5'd0, 6'd0, 6'd0));
    send_word(load_word(5'd23, 6'd59, 6'd59));
    send_word(load_word(5'd9, 6'd9, 6'd7));
    send_word(load_word(5'd31, 6'd63, 6'd63));
    send_word(load_word(5'd16, 6'd32, 6'd8));
  endtask

  task automatic test_carry_chain();
    set_reg(CFG_TICKS_PER_SECOND, 8'd1);
    send_word(load_word(5'd23, 6'd59, 6'd58));
    send_word(tick_word());
    send_word(tick_word());
    // out of range: wraps without carry
    send_word(load_word(5'd31, 6'd63, 6'd63));
    send_word(tick_word());
    send_word(load_word(5'd9, 6'd59, 6'd59));
    send_word(tick_word());
  endtask

  task automatic test_blink_points();
    set_reg(CFG_TICKS_PER_SECOND, 8'd4);
    set_reg(CFG_BLINK_POINT_FIRST, 8'd0);
    set_reg(CFG_BLINK_POINT_SECOND, 8'd3);
    send_word(load_word(5'd12, 6'd34, 6'd56));
    repeat (5) send_word(tick_word());
  endtask

  task automatic test_zero_period();
    set_reg(CFG_TICKS_PER_SECOND, 8'd0);
    repeat (2) send_word(tick_word());
  endtask

  task automatic test_prescaler_overrun();
    set_reg(CFG_TICKS_PER_SECOND, 8'd3);
    send_word(load_word(5'd1, 6'd2, 6'd3));
    repeat (2) send_word(tick_word());
    // prescaler now at the new period
    set_reg(CFG_TICKS_PER_SECOND, 8'd2);
    send_word(tick_word());
  endtask

  task automatic test_random_phase(input logic [7:0] t, input logic [7:0] a,
                                   input logic [7:0] b, input int count);
    set_reg(CFG_TICKS_PER_SECOND, t);
    set_reg(CFG_BLINK_POINT_FIRST, a);
    set_reg(CFG_BLINK_POINT_SECOND, b);
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) no_idle = ($urandom_range(0, 2) == 0);
      if (i == count / 2) drain_results();
      send_word(random_word());
    end
    no_idle = 1'b0;
  endtask

  initial begin : main
    logic [7:0] t;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_word_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    tps = TicksPerSecondRst;
    blink_a = BlinkPointFirstRst;
    blink_b = BlinkPointSecondRst;
    pre = PrescaleRst;
    sec = SecondsRst;
    mins = MinutesRst;
    hrs = HoursRst;
    led = IndicatorRst;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_time();
    test_load_extremes();
    test_carry_chain();
    test_blink_points();
    test_zero_period();
    test_prescaler_overrun();

    test_random_phase(8'd1, 8'd0, 8'd255, 200);
    test_random_phase(8'd0, 8'd0, 8'd0, 150);
    test_random_phase(8'd255, 8'd255, 8'd0, 150);
    t = 8'($urandom_range(2, 12));
    test_random_phase(t, 8'($urandom_range(0, t)), 8'($urandom_range(0, t)), 250);
    test_random_phase(TicksPerSecondRst, BlinkPointFirstRst, BlinkPointSecondRst, 200);
    test_random_phase(8'($urandom), 8'($urandom), 8'($urandom), 250);

    drain_results();
    repeat (4) @(posedge clk_i);
    if (n_mismatch == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
